// ===== rtl/scx_pkg.sv =====
// Shared types and constants of the masked Scale2x upscaler.
package scx_pkg;

    // Widths fixed by the pixel and register formats.
    localparam int CH_W  = 8;
    localparam int COL_W_RGB = 3 * CH_W;
    localparam int CFG_W = 9;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_ROW_WIDTH = 1'b0,
        REG_ROW_COUNT = 1'b1
    } t_reg_idx;

    // Register values after reset.
    localparam logic [CFG_W-1:0] ROW_WIDTH_RST = 9'd208;
    localparam logic [CFG_W-1:0] ROW_COUNT_RST = 9'd256;

    // One stored pixel; a transparent pixel is kept as all zeros.
    typedef struct packed {
        logic                 opaque;
        logic [COL_W_RGB-1:0] colour;
    } t_pix;

    localparam t_pix PIX_CLEAR = '0;

    // One column of the two line buffers.
    typedef struct packed {
        t_pix upper;
        t_pix centre;
    } t_entry;

    // One 2x2 output block.
    typedef struct packed {
        logic [COL_W_RGB-1:0] top_left_colour;
        logic                 top_left_opaque;
        logic [COL_W_RGB-1:0] top_right_colour;
        logic                 top_right_opaque;
        logic [COL_W_RGB-1:0] bottom_left_colour;
        logic                 bottom_left_opaque;
        logic [COL_W_RGB-1:0] bottom_right_colour;
        logic                 bottom_right_opaque;
        logic                 frame_done;
    } t_block;

endpackage

// ===== rtl/scx_in_if.sv =====
// Source pixel channel: valid, ready and one RGB pixel with its opaque flag.
interface scx_in_if;
    import scx_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            opaque;

    modport source (output valid, output red, output green, output blue,
                    output opaque, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input opaque, output ready);
endinterface

// ===== rtl/scx_out_if.sv =====
// Result channel: valid, ready and one 2x2 block of masked pixels.
interface scx_out_if;
    import scx_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [COL_W_RGB-1:0] top_left_colour;
    logic                 top_left_opaque;
    logic [COL_W_RGB-1:0] top_right_colour;
    logic                 top_right_opaque;
    logic [COL_W_RGB-1:0] bottom_left_colour;
    logic                 bottom_left_opaque;
    logic [COL_W_RGB-1:0] bottom_right_colour;
    logic                 bottom_right_opaque;
    logic                 frame_done;

    modport source (output valid, output top_left_colour, output top_left_opaque,
                    output top_right_colour, output top_right_opaque,
                    output bottom_left_colour, output bottom_left_opaque,
                    output bottom_right_colour, output bottom_right_opaque,
                    output frame_done, input ready);
    modport sink   (input valid, input top_left_colour, input top_left_opaque,
                    input top_right_colour, input top_right_opaque,
                    input bottom_left_colour, input bottom_left_opaque,
                    input bottom_right_colour, input bottom_right_opaque,
                    input frame_done, output ready);
endinterface

// ===== rtl/scx_cell.sv =====
// One column cell of the rotating line-buffer ring (upper and centre pixel).
module scx_cell #(
    parameter int MAX_ROW_WIDTH = 256,
    parameter int IDX           = 0
) (
    input  logic                               i_clk,
    input  logic                               i_shift,
    input  logic [$clog2(MAX_ROW_WIDTH)-1:0]   i_last_col,
    input  scx_pkg::t_entry                    i_next,
    input  scx_pkg::t_entry                    i_wrap,
    output scx_pkg::t_entry                    o_entry
);
    import scx_pkg::*;

    localparam int COL_W = $clog2(MAX_ROW_WIDTH);
    localparam logic [COL_W-1:0] MY_COL = COL_W'(IDX);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_active;

    // Cells past the last column in use hold their contents.
    assign w_active = (MY_COL <= i_last_col);

    // The last active cell closes the ring with the newly written column;
    // every other active cell takes its right neighbor.
    always_comb begin
        n_entry = r_entry;
        if (i_shift && w_active) begin
            if (MY_COL == i_last_col) begin
                n_entry = i_wrap;
            end else begin
                n_entry = i_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== rtl/scx_kernel.sv =====
// Scale2x corner selection for one centre pixel with transparency masks.
module scx_kernel (
    input  scx_pkg::t_pix   i_b,
    input  scx_pkg::t_pix   i_d,
    input  scx_pkg::t_pix   i_e,
    input  scx_pkg::t_pix   i_f,
    input  scx_pkg::t_pix   i_h,
    input  logic            i_frame_done,
    output scx_pkg::t_block o_blk
);
    import scx_pkg::*;

    logic w_edge;
    t_pix w_tl;
    t_pix w_tr;
    t_pix w_bl;
    t_pix w_br;

    // Transparent pixels are stored as zero, so plain equality already
    // treats two transparent pixels as equal and never matches opaque ones.
    assign w_edge = i_e.opaque && (i_b != i_h) && (i_d != i_f);

    always_comb begin
        w_tl = i_e;
        w_tr = i_e;
        w_bl = i_e;
        w_br = i_e;
        if (w_edge) begin
            if (i_d == i_b) begin
                w_tl = i_d;
            end
            if (i_b == i_f) begin
                w_tr = i_f;
            end
            if (i_d == i_h) begin
                w_bl = i_d;
            end
            if (i_h == i_f) begin
                w_br = i_f;
            end
        end
    end

    // Pack the four corners into one output word.
    always_comb begin
        o_blk.top_left_colour     = w_tl.colour;
        o_blk.top_left_opaque     = w_tl.opaque;
        o_blk.top_right_colour    = w_tr.colour;
        o_blk.top_right_opaque    = w_tr.opaque;
        o_blk.bottom_left_colour  = w_bl.colour;
        o_blk.bottom_left_opaque  = w_bl.opaque;
        o_blk.bottom_right_colour = w_br.colour;
        o_blk.bottom_right_opaque = w_br.opaque;
        o_blk.frame_done          = i_frame_done;
    end

endmodule

// ===== rtl/scale2x_masked_upscaler.sv =====
// Top level of the masked Scale2x upscaler: column ring, kernel and output buffer.
// A 2x2 word is registered into the output buffer when the pixel below it is taken;
// the two-entry buffer keeps input flowing while a word waits. Throughput: one pixel per cycle,
// stalled while the skid stage is full and while the ring realigns after a mid-row width change.
// Reset (synchronous, active low) clears counters, buffer state and the registers
// to width 208 and 256 rows; the line cells are not cleared and are rewritten by the feed.
module scale2x_masked_upscaler #(
    parameter int MAX_ROW_WIDTH = 256,
    parameter int MAX_ROWS      = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  scx_pkg::t_reg_idx         i_cfg_idx,
    input  logic [scx_pkg::CFG_W-1:0] i_cfg_data,
    scx_in_if.sink                    i_pix,
    scx_out_if.source                 o_blk
);
    import scx_pkg::*;

    localparam int COL_W = $clog2(MAX_ROW_WIDTH);
    localparam int WID_W = $clog2(MAX_ROW_WIDTH + 1);
    localparam int WCMP_W = (CFG_W > WID_W) ? CFG_W : WID_W;
    localparam int RC_W  = $clog2(MAX_ROWS + 1);
    localparam int RCMP_W = (CFG_W > RC_W) ? CFG_W : RC_W;
    localparam int ROW_W = $clog2(MAX_ROWS + 2);

    // Configuration registers.
    logic [CFG_W-1:0] r_row_width;
    logic [CFG_W-1:0] r_row_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_RST;
            r_row_count <= ROW_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROW_WIDTH: r_row_width <= i_cfg_data;
                REG_ROW_COUNT: r_row_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Saturate the registers to the supported ranges.
    logic [WCMP_W-1:0] w_rw_ext;
    logic [RCMP_W-1:0] w_rc_ext;
    logic [WID_W-1:0]  w_width;
    logic [RC_W-1:0]   w_rows;

    assign w_rw_ext = WCMP_W'(r_row_width);
    assign w_rc_ext = RCMP_W'(r_row_count);

    always_comb begin
        if (w_rw_ext == '0) begin
            w_width = WID_W'(1);
        end else if (w_rw_ext > WCMP_W'(MAX_ROW_WIDTH)) begin
            w_width = WID_W'(MAX_ROW_WIDTH);
        end else begin
            w_width = WID_W'(w_rw_ext);
        end
        if (w_rc_ext == '0) begin
            w_rows = RC_W'(1);
        end else if (w_rc_ext > RCMP_W'(MAX_ROWS)) begin
            w_rows = RC_W'(MAX_ROWS);
        end else begin
            w_rows = RC_W'(w_rc_ext);
        end
    end

    // Position counters.
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_feed;
    logic [COL_W-1:0] w_last_col;
    logic [COL_W-1:0] w_col;
    logic             w_row_end;
    logic             w_frame_end;
    logic             w_emit;

    assign w_last_col  = COL_W'(w_width - WID_W'(1));
    assign w_col       = (WID_W'(r_col) >= w_width) ? w_last_col : r_col;
    assign w_row_end   = (w_col == w_last_col);
    assign w_frame_end = (r_feed >= (ROW_W'(w_rows) + ROW_W'(1)));
    assign w_emit      = (r_feed >= ROW_W'(2));

    // Ring alignment: cell 0 holds column r_pos of a ring that closes at r_ring_lc.
    // At column 0 the ring is in plain column order and may take a new width at once;
    // otherwise it first rotates back to column 0, then forward to the current column.
    logic [COL_W-1:0] r_pos;
    logic [COL_W-1:0] r_ring_lc;
    logic [COL_W-1:0] w_use_lc;
    logic             w_aligned;

    assign w_use_lc  = (r_pos == '0) ? w_last_col : r_ring_lc;
    assign w_aligned = (w_use_lc == w_last_col) && (r_pos == w_col);

    // Handshake on the input side.
    logic r_ov;
    logic r_sv;
    logic w_in_acc;
    logic w_push;
    logic w_pop;
    logic w_shift;

    assign i_pix.ready = !r_sv && w_aligned;
    assign w_in_acc    = i_pix.valid && !r_sv && w_aligned;
    assign w_push      = w_in_acc && w_emit;
    assign w_pop       = r_ov && o_blk.ready;
    assign w_shift     = w_in_acc || !w_aligned;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_feed <= '0;
        end else if (w_in_acc) begin
            if (w_row_end) begin
                r_col <= '0;
                if (w_frame_end) begin
                    r_feed <= '0;
                end else begin
                    r_feed <= r_feed + ROW_W'(1);
                end
            end else begin
                r_col <= w_col + COL_W'(1);
            end
        end
    end

    // The ring position moves with every rotation, wrapping at the ring's last column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_ring_lc <= '0;
        end else begin
            r_ring_lc <= w_use_lc;
            if (w_shift) begin
                r_pos <= (r_pos == w_use_lc) ? '0 : r_pos + COL_W'(1);
            end
        end
    end

    // Incoming pixel as stored: transparent pixels become zero.
    t_pix w_h;

    always_comb begin
        w_h = PIX_CLEAR;
        if (i_pix.opaque) begin
            w_h.opaque = 1'b1;
            w_h.colour = {i_pix.red, i_pix.green, i_pix.blue};
        end
    end

    // Ring of column cells: cell 0 holds the current column whenever the ring is aligned.
    t_entry w_ent [MAX_ROW_WIDTH];
    t_entry w_wrap;
    t_pix   w_b;
    t_pix   w_e;
    t_pix   w_f;
    t_pix   w_d;
    t_pix   r_left;

    assign w_b    = w_ent[0].upper;
    assign w_e    = w_ent[0].centre;
    assign w_f    = w_row_end ? PIX_CLEAR : w_ent[1].centre;
    assign w_d    = (w_col == '0) ? PIX_CLEAR : r_left;

    // A taken pixel closes the ring with the rewritten column; a realigning
    // rotation carries cell 0 round unchanged.
    assign w_wrap = w_aligned ? '{upper: w_e, centre: w_h} : w_ent[0];

    for (genvar g = 0; g < MAX_ROW_WIDTH; g++) begin : g_cell
        t_entry w_next;
        if (g == MAX_ROW_WIDTH - 1) begin : g_end
            assign w_next = w_wrap;
        end else begin : g_mid
            assign w_next = w_ent[g+1];
        end
        scx_cell #(
            .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
            .IDX           (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_shift    (w_shift),
            .i_last_col (w_use_lc),
            .i_next     (w_next),
            .i_wrap     (w_wrap),
            .o_entry    (w_ent[g])
        );
    end

    // Left neighbor is the previous centre pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= PIX_CLEAR;
        end else if (w_in_acc) begin
            r_left <= w_e;
        end
    end

    // Corner selection.
    t_block w_blk;

    scx_kernel u_kernel (
        .i_b          (w_b),
        .i_d          (w_d),
        .i_e          (w_e),
        .i_f          (w_f),
        .i_h          (w_h),
        .i_frame_done (w_frame_end && w_row_end),
        .o_blk        (w_blk)
    );

    // Output register with a skid stage behind it.
    t_block r_out;
    t_block r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || o_blk.ready) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= w_push;
            end
        end else if (w_push) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || o_blk.ready) begin
            if (r_sv) begin
                r_out <= r_skid;
            end else if (w_push) begin
                r_out <= w_blk;
            end
        end else if (w_push) begin
            r_skid <= w_blk;
        end
    end

    assign o_blk.valid               = r_ov;
    assign o_blk.top_left_colour     = r_out.top_left_colour;
    assign o_blk.top_left_opaque     = r_out.top_left_opaque;
    assign o_blk.top_right_colour    = r_out.top_right_colour;
    assign o_blk.top_right_opaque    = r_out.top_right_opaque;
    assign o_blk.bottom_left_colour  = r_out.bottom_left_colour;
    assign o_blk.bottom_left_opaque  = r_out.bottom_left_opaque;
    assign o_blk.bottom_right_colour = r_out.bottom_right_colour;
    assign o_blk.bottom_right_opaque = r_out.bottom_right_opaque;
    assign o_blk.frame_done          = r_out.frame_done;

`ifndef SYNTHESIS
    // The skid stage only fills behind a waiting output word.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid stage holds a word while the output is empty");

    // A parked word stays parked until the output drains.
    a_skid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && !o_blk.ready) |=> r_sv)
        else $error("skid word lost while the output was stalled");

    // The last block of a frame restarts both counters.
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_row_end && w_frame_end) |=> (r_col == '0 && r_feed == '0))
        else $error("counters did not restart after the frame end");

    // Warm-up rows never produce a word.
    a_no_warmup_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_feed < ROW_W'(2) && !r_ov) |=> !r_ov)
        else $error("a word came out during the warm-up rows");
`endif

endmodule
